[rtl/shamh_pkg.sv]
// ----------------------------------------------------------------------------
// shamh_pkg: shared types and constants for the SHA-256 message hasher
// Item structs for both channels, round constants and the initial hash value.
// ----------------------------------------------------------------------------
`default_nettype none

package shamh_pkg;

  typedef struct packed {
    logic [7:0] byte_data;
    logic       has_byte;
    logic       is_last;
  } shamh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } shamh_out_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned NUM_STATE  = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_HASH [NUM_STATE] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

[rtl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher: byte-serial SHA-256 with one shared round unit
// Flow: a byte that does not end a block is taken while idle. The 64th byte
//   of a block starts 64 rounds and then one chaining fold.
// Last item: a padding step, 64 rounds and a fold, plus a length step, 64
//   more rounds and a fold when the 0x80 marker lands at offset 56 or later;
//   then 8 digest items, one per cycle at most. Bytes are taken only in idle.
// Reset: synchronous; chaining value back to the initial hash, length cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  msg_valid,
  output      logic                  msg_ready,
  input  wire shamh_pkg::shamh_in_t  msg,
  output      logic                  dig_valid,
  input  wire logic                  dig_ready,
  output      shamh_pkg::shamh_out_t dig
);

  import shamh_pkg::*;

  // Sequencer. The block buffer doubles as the 16-word schedule shift line
  // while the rounds run; its contents are dead once a compression is done.
  typedef enum logic [2:0] {
    S_IDLE,   // taking bytes
    S_PAD,    // drop in 0x80, clear the tail, maybe the length
    S_LEN,    // second padding block: zeros and the length
    S_ROUND,  // one round per cycle
    S_FOLD,   // chain += working registers
    S_OUT     // hand out the eight digest words
  } state_t;

  // What follows the chaining fold.
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_LEN,
    AFT_OUT
  } after_t;

  state_t      state;
  after_t      next_step;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic [60:0] bytes_seen;
  logic [31:0] chain [NUM_STATE];
  logic [31:0] wr    [NUM_STATE];   // a..h
  logic [31:0] blk   [NUM_WORDS];

  logic [5:0]  pos;
  logic [3:0]  pos_word;
  logic [7:0]  ins_byte;
  logic [31:0] ins_word;
  logic [63:0] len_bits;
  logic [31:0] w_sched;
  logic [31:0] wj;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] sm_s0;
  logic [31:0] sm_s1;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Byte placement: big-endian within the word, offset 0 starts the word fresh.
  assign pos      = bytes_seen[5:0];
  assign pos_word = pos[5:2];
  assign ins_byte = (state == S_PAD) ? PAD_BYTE : msg.byte_data;
  assign len_bits = {bytes_seen, 3'b000};

  always_comb begin
    if (pos[1:0] == 2'd0) begin
      ins_word = {ins_byte, 24'h000000};
    end else begin
      ins_word = blk[pos_word] | (32'(ins_byte) << {~pos[1:0], 3'b000});
    end
  end

  // Round unit.
  always_comb begin
    sm_s0   = rotr(blk[1], 7) ^ rotr(blk[1], 18) ^ (blk[1] >> 3);
    sm_s1   = rotr(blk[14], 17) ^ rotr(blk[14], 19) ^ (blk[14] >> 10);
    w_sched = blk[0] + sm_s0 + blk[9] + sm_s1;
    wj      = (round[5:4] == 2'b00) ? blk[0] : w_sched;
    big_s1  = rotr(wr[4], 6) ^ rotr(wr[4], 11) ^ rotr(wr[4], 25);
    ch      = (wr[4] & wr[5]) ^ (~wr[4] & wr[6]);
    t1      = wr[7] + big_s1 + ch + ROUND_K[round] + wj;
    big_s0  = rotr(wr[0], 2) ^ rotr(wr[0], 13) ^ rotr(wr[0], 22);
    maj     = (wr[0] & wr[1]) ^ (wr[0] & wr[2]) ^ (wr[1] & wr[2]);
    t2      = big_s0 + maj;
  end

  assign msg_ready       = (state == S_IDLE);
  assign dig_valid       = (state == S_OUT);
  assign dig.digest_word = chain[out_idx];
  assign dig.word_index  = out_idx;
  assign dig.final_word  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_step  <= AFT_IDLE;
      round      <= '0;
      out_idx    <= '0;
      bytes_seen <= '0;
      for (int i = 0; i < NUM_STATE; i++) begin
        chain[i] <= INIT_HASH[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (msg_valid) begin
            if (msg.has_byte) begin
              blk[pos_word] <= ins_word;
              bytes_seen    <= bytes_seen + 61'd1;
            end
            if (msg.has_byte && pos == 6'd63) begin
              // block full: compress, then pad if this item also ends it
              wr        <= chain;
              round     <= '0;
              next_step <= msg.is_last ? AFT_PAD : AFT_IDLE;
              state     <= S_ROUND;
            end else if (msg.is_last) begin
              state <= S_PAD;
            end
          end
        end

        S_PAD: begin
          if (pos[5:3] == 3'b111) begin
            // no room for the length; it goes in a block of its own
            for (int i = 0; i < NUM_WORDS; i++) begin
              if (4'(i) > pos_word) begin
                blk[i] <= '0;
              end
            end
            next_step <= AFT_LEN;
          end else begin
            for (int i = 0; i < NUM_WORDS - 2; i++) begin
              if (4'(i) > pos_word) begin
                blk[i] <= '0;
              end
            end
            blk[14]   <= len_bits[63:32];
            blk[15]   <= len_bits[31:0];
            next_step <= AFT_OUT;
          end
          blk[pos_word] <= ins_word;
          wr    <= chain;
          round <= '0;
          state <= S_ROUND;
        end

        S_LEN: begin
          for (int i = 0; i < NUM_WORDS - 2; i++) begin
            blk[i] <= '0;
          end
          blk[14]   <= len_bits[63:32];
          blk[15]   <= len_bits[31:0];
          next_step <= AFT_OUT;
          wr        <= chain;
          round     <= '0;
          state     <= S_ROUND;
        end

        S_ROUND: begin
          wr[7] <= wr[6];
          wr[6] <= wr[5];
          wr[5] <= wr[4];
          wr[4] <= wr[3] + t1;
          wr[3] <= wr[2];
          wr[2] <= wr[1];
          wr[1] <= wr[0];
          wr[0] <= t1 + t2;
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            blk[i] <= blk[i + 1];
          end
          blk[NUM_WORDS - 1] <= wj;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end

        S_FOLD: begin
          for (int i = 0; i < NUM_STATE; i++) begin
            chain[i] <= chain[i] + wr[i];
          end
          unique case (next_step)
            AFT_IDLE: state <= S_IDLE;
            AFT_PAD:  state <= S_PAD;
            AFT_LEN:  state <= S_LEN;
            AFT_OUT: begin
              out_idx <= '0;
              state   <= S_OUT;
            end
            default:  state <= S_IDLE;
          endcase
        end

        S_OUT: begin
          if (dig_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < NUM_STATE; i++) begin
                chain[i] <= INIT_HASH[i];
              end
              bytes_seen <= '0;
              state      <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // One item in flight at a time: input and digest never open together.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("input and digest channels open together");

  // The last digest word hands control back to the input side.
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && dig.final_word) |=> msg_ready)
    else $error("not idle after last digest word");

  // A full block always gets its 64 rounds before the fold.
  a_rounds_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(round) == 6'd63 && $past(state) == S_ROUND))
    else $error("fold without a full round sweep");

  // Digest words start at index zero.
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> (dig.word_index == 3'd0))
    else $error("digest does not start at word zero");

endmodule

`default_nettype wire
